@@ sv/pscc_pkg.sv @@
`default_nettype none
// ============================================================================
// pscc_pkg
// Shared types and constants of the per-source connection counter: item
// structs, table word layouts, controller states and command/status bundles.
// ============================================================================
package pscc_pkg;

    // Default table sizes
    localparam int ADDR_ENTRIES_DEF = 64;
    localparam int LINK_ENTRIES_DEF = 256;

    // Field widths
    localparam int PID_W = 22;
    localparam int IP_W  = 32;
    localparam int CNT_W = 9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Event codes carried in the func field
    localparam logic FUNC_OPEN  = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PID_W-1:0] proc_id;
        logic [IP_W-1:0]  client_addr;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] new_count;
        logic             pid_unknown;
        logic             table_full;
    } t_out_item;

    // Link table word: process id to client address
    typedef struct packed {
        logic             valid;
        logic [PID_W-1:0] pid;
        logic [IP_W-1:0]  addr;
    } t_link_word;

    // Address table word: client address and its connection count
    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  key;
        logic [CNT_W-1:0] count;
    } t_addr_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LSCAN,
        S_ASCAN,
        S_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic scan_link;
        logic scan_addr;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ sv/pscc_ram.sv @@
`default_nettype none
// ============================================================================
// pscc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module pscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/pscc_ctrl.sv @@
`default_nettype none
// ============================================================================
// pscc_ctrl
// Sequencer: clearing pass after reset, then per event a link table scan,
// an address table scan and a commit into the output register.
// ============================================================================
module pscc_ctrl import pscc_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LSCAN;
                end
            end
            S_LSCAN: begin
                o_cmd.scan_link = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_ASCAN;
                end
            end
            S_ASCAN: begin
                o_cmd.scan_addr = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/pscc_dp.sv @@
`default_nettype none
// ============================================================================
// pscc_dp
// Datapath: link and address tables in RAM, the scan index and compare
// pipeline, the hit/free trackers, the update logic and the output register.
// ============================================================================
module pscc_dp import pscc_pkg::*; #(
    parameter int ADDR_ENTRIES = ADDR_ENTRIES_DEF,
    parameter int LINK_ENTRIES = LINK_ENTRIES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_sts       o_sts,
    input  wire t_in_item i_in_item,
    output t_out_item     o_out_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall
);

    localparam int AW    = $clog2(ADDR_ENTRIES);
    localparam int LW    = $clog2(LINK_ENTRIES);
    localparam int MAX_N = (ADDR_ENTRIES > LINK_ENTRIES) ? ADDR_ENTRIES : LINK_ENTRIES;
    localparam int MW    = $clog2(MAX_N + 1);

    localparam logic [MW-1:0] A_N      = MW'(ADDR_ENTRIES);
    localparam logic [MW-1:0] L_N      = MW'(LINK_ENTRIES);
    localparam logic [MW-1:0] A_LAST   = MW'(ADDR_ENTRIES - 1);
    localparam logic [MW-1:0] L_LAST   = MW'(LINK_ENTRIES - 1);
    localparam logic [MW-1:0] MAX_LAST = MW'(MAX_N - 1);

    // Registers
    t_in_item         r_item,     n_item;
    logic [MW-1:0]    r_idx,      n_idx;
    logic             r_rd_vld,   n_rd_vld;
    logic [MW-1:0]    r_rd_idx,   n_rd_idx;
    logic             r_l_hit,    n_l_hit;
    logic [LW-1:0]    r_l_idx,    n_l_idx;
    logic [IP_W-1:0]  r_l_addr,   n_l_addr;
    logic             r_lf,       n_lf;
    logic [LW-1:0]    r_lf_idx,   n_lf_idx;
    logic             r_a_hit,    n_a_hit;
    logic [AW-1:0]    r_a_idx,    n_a_idx;
    logic [CNT_W-1:0] r_a_cnt,    n_a_cnt;
    logic             r_af,       n_af;
    logic [AW-1:0]    r_af_idx,   n_af_idx;
    t_out_item        r_out,      n_out;
    logic             r_out_vld,  n_out_vld;

    // Table ports
    logic [$bits(t_link_word)-1:0] link_rdata;
    logic [$bits(t_addr_word)-1:0] addr_rdata;
    t_link_word                    link_rd, link_wd;
    t_addr_word                    addr_rd, addr_wd;
    logic                          link_we, addr_we;
    logic [LW-1:0]                 link_wa;
    logic [AW-1:0]                 addr_wa;

    logic             scanning;
    logic             issue;
    logic [MW-1:0]    issue_lim;
    logic [MW-1:0]    scan_last;
    logic             scan_done;
    logic             clear_done;
    logic [IP_W-1:0]  scan_key;
    t_out_item        commit_out;
    logic [CNT_W-1:0] upd_cnt;

    assign link_rd = t_link_word'(link_rdata);
    assign addr_rd = t_addr_word'(addr_rdata);

    pscc_ram #(
        .WIDTH ($bits(t_link_word)),
        .DEPTH (LINK_ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (r_idx[LW-1:0]),
        .o_rdata (link_rdata)
    );

    pscc_ram #(
        .WIDTH ($bits(t_addr_word)),
        .DEPTH (ADDR_ENTRIES)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (addr_wa),
        .i_wdata (addr_wd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (addr_rdata)
    );

    // Scan bookkeeping
    assign scanning   = i_cmd.scan_link || i_cmd.scan_addr;
    assign issue_lim  = i_cmd.scan_link ? L_N : A_N;
    assign scan_last  = i_cmd.scan_link ? L_LAST : A_LAST;
    assign issue      = scanning && (r_idx < issue_lim);
    assign scan_done  = scanning && r_rd_vld && (r_rd_idx == scan_last);
    assign clear_done = i_cmd.clear && (r_idx == MAX_LAST);
    // a close looks up the address its link points at
    assign scan_key   = (r_item.func == FUNC_CLOSE) ? r_l_addr : r_item.client_addr;

    assign o_sts.clear_done = clear_done;
    assign o_sts.scan_done  = scan_done;
    assign o_sts.out_free   = !r_out_vld || !i_out_stall;

    // Table writes and the result of the event
    always_comb begin
        link_we    = 1'b0;
        link_wa    = r_idx[LW-1:0];
        link_wd    = '0;
        addr_we    = 1'b0;
        addr_wa    = r_idx[AW-1:0];
        addr_wd    = '0;
        commit_out = '0;
        upd_cnt    = '0;
        if (i_cmd.clear) begin
            link_we = (r_idx < L_N);
            addr_we = (r_idx < A_N);
        end else if (r_item.func == FUNC_OPEN) begin
            // open: needs an address slot and a link slot
            if (!(r_a_hit || r_af) || !(r_l_hit || r_lf)) begin
                commit_out.table_full = 1'b1;
            end else begin
                if (!r_a_hit) begin
                    upd_cnt = CNT_W'(1);
                end else if (r_a_cnt == CNT_MAX) begin
                    upd_cnt = r_a_cnt;
                end else begin
                    upd_cnt = r_a_cnt + 1'b1;
                end
                link_we       = i_cmd.commit;
                link_wa       = r_l_hit ? r_l_idx : r_lf_idx;
                link_wd.valid = 1'b1;
                link_wd.pid   = r_item.proc_id;
                link_wd.addr  = r_item.client_addr;
                addr_we       = i_cmd.commit;
                addr_wa       = r_a_hit ? r_a_idx : r_af_idx;
                addr_wd.valid = 1'b1;
                addr_wd.key   = r_item.client_addr;
                addr_wd.count = upd_cnt;
                commit_out.new_count = upd_cnt;
            end
        end else if (!r_l_hit) begin
            commit_out.pid_unknown = 1'b1;
        end else begin
            // close: drop the link, count down the address if present
            link_we       = i_cmd.commit;
            link_wa       = r_l_idx;
            link_wd.valid = 1'b0;
            link_wd.pid   = r_item.proc_id;
            link_wd.addr  = r_l_addr;
            if (r_a_hit && (r_a_cnt != '0)) begin
                upd_cnt       = r_a_cnt - 1'b1;
                addr_we       = i_cmd.commit;
                addr_wa       = r_a_idx;
                addr_wd.valid = (upd_cnt != '0);
                addr_wd.key   = scan_key;
                addr_wd.count = upd_cnt;
                commit_out.new_count = upd_cnt;
            end
        end
    end

    // Next values of the datapath registers
    always_comb begin
        n_item    = r_item;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_l_hit   = r_l_hit;
        n_l_idx   = r_l_idx;
        n_l_addr  = r_l_addr;
        n_lf      = r_lf;
        n_lf_idx  = r_lf_idx;
        n_a_hit   = r_a_hit;
        n_a_idx   = r_a_idx;
        n_a_cnt   = r_a_cnt;
        n_af      = r_af;
        n_af_idx  = r_af_idx;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        // clearing pass index
        if (i_cmd.clear) begin
            n_idx = clear_done ? '0 : r_idx + 1'b1;
        end

        // new event
        if (i_cmd.load) begin
            n_item   = i_in_item;
            n_idx    = '0;
            n_rd_vld = 1'b0;
            n_l_hit  = 1'b0;
            n_lf     = 1'b0;
            n_a_hit  = 1'b0;
            n_af     = 1'b0;
        end

        // read issue and compare, one entry per cycle
        if (scanning) begin
            n_rd_vld = issue;
            n_rd_idx = r_idx;
            if (issue) begin
                n_idx = r_idx + 1'b1;
            end
            if (r_rd_vld && i_cmd.scan_link) begin
                if (link_rd.valid && (link_rd.pid == r_item.proc_id) && !r_l_hit) begin
                    n_l_hit  = 1'b1;
                    n_l_idx  = r_rd_idx[LW-1:0];
                    n_l_addr = link_rd.addr;
                end
                if (!link_rd.valid && !r_lf) begin
                    n_lf     = 1'b1;
                    n_lf_idx = r_rd_idx[LW-1:0];
                end
            end
            if (r_rd_vld && i_cmd.scan_addr) begin
                if (addr_rd.valid && (addr_rd.key == scan_key) && !r_a_hit) begin
                    n_a_hit = 1'b1;
                    n_a_idx = r_rd_idx[AW-1:0];
                    n_a_cnt = addr_rd.count;
                end
                if (!addr_rd.valid && !r_af) begin
                    n_af     = 1'b1;
                    n_af_idx = r_rd_idx[AW-1:0];
                end
            end
            if (scan_done) begin
                n_idx    = '0;
                n_rd_vld = 1'b0;
            end
        end

        // output register
        if (i_cmd.commit) begin
            n_out     = commit_out;
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_rd_idx <= n_rd_idx;
        r_l_hit  <= n_l_hit;
        r_l_idx  <= n_l_idx;
        r_l_addr <= n_l_addr;
        r_lf     <= n_lf;
        r_lf_idx <= n_lf_idx;
        r_a_hit  <= n_a_hit;
        r_a_idx  <= n_a_idx;
        r_a_cnt  <= n_a_cnt;
        r_af     <= n_af;
        r_af_idx <= n_af_idx;
        r_out    <= n_out;
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_vld;

`ifndef NO_ASSERTIONS
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_vld || !i_out_stall))
        else $error("commit while output register is held");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_vld)
        else $error("committed result not presented");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.pid_unknown && r_out.table_full))
        else $error("both error flags raised");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.pid_unknown || r_out.table_full)) |-> (r_out.new_count == '0))
        else $error("nonzero count on error result");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scanning |-> (!link_we && !addr_we))
        else $error("table write during scan");
`endif

endmodule
`default_nettype wire

@@ sv/per_source_connection_counter.sv @@
`default_nettype none
// ============================================================================
// per_source_connection_counter
// Counts open connections per client IPv4 address and keeps the link from
// each process id to its address.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one open or close
//   event per transfer. Output channel (o_out_valid / i_out_stall /
//   o_out_item): exactly one result per event, in order.
//   Each event walks the whole link table, then the whole address table,
//   one entry per cycle through the RAM read port, then writes the
//   tables in the commit state once the output register is free. One event
//   is taken at a time: the next one is accepted only after the commit.
//   After reset the block runs a clearing pass over both tables with
//   o_in_stall high.
//   A result waits in the output register while i_out_stall is high; the
//   next event is still accepted and scanned, and its commit waits until
//   the output register is free.
// ============================================================================
module per_source_connection_counter import pscc_pkg::*; #(
    parameter int ADDR_ENTRIES = ADDR_ENTRIES_DEF,
    parameter int LINK_ENTRIES = LINK_ENTRIES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pscc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    pscc_dp #(
        .ADDR_ENTRIES (ADDR_ENTRIES),
        .LINK_ENTRIES (LINK_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire

@@ sim/pscc_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pscc_checker
// Watches both channels of the per-source connection counter. Keeps its own
// copy of the address and link tables, predicts the result of each accepted
// event and compares every accepted result against the oldest prediction.
// ============================================================================
module pscc_checker import pscc_pkg::*; #(
    parameter int ADDR_ENTRIES = ADDR_ENTRIES_DEF,
    parameter int LINK_ENTRIES = LINK_ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int MAX_REPORTS = 10;

    // Mirror of the address table
    logic [IP_W-1:0]  ip_key   [ADDR_ENTRIES];
    logic [CNT_W-1:0] ip_conns [ADDR_ENTRIES];
    logic             ip_used  [ADDR_ENTRIES];

    // Mirror of the link table
    logic [PID_W-1:0] owner_pid  [LINK_ENTRIES];
    logic [IP_W-1:0]  owner_ip   [LINK_ENTRIES];
    logic             owner_used [LINK_ENTRIES];

    t_out_item pending_outcomes[$];
    int        faults;

    // Lowest live entry holding ip, and lowest free entry
    function automatic void scan_ips(input logic [IP_W-1:0] ip, output int hit,
                                     output int spare);
        hit   = -1;
        spare = -1;
        for (int n = 0; n < ADDR_ENTRIES; n++) begin
            if (ip_used[n] && ip_key[n] == ip && hit < 0)
                hit = n;
            if (!ip_used[n] && spare < 0)
                spare = n;
        end
    endfunction

    // Apply one open/close event to the mirror tables and return its outcome
    function automatic t_out_item apply_conn_event(input t_in_item ev);
        t_out_item res;
        int        pid_hit;
        int        pid_spare;
        int        ip_hit;
        int        ip_spare;
        int        ip_slot;
        int        pid_slot;
        res       = '0;
        pid_hit   = -1;
        pid_spare = -1;
        for (int n = 0; n < LINK_ENTRIES; n++) begin
            if (owner_used[n] && owner_pid[n] == ev.proc_id && pid_hit < 0)
                pid_hit = n;
            if (!owner_used[n] && pid_spare < 0)
                pid_spare = n;
        end

        if (ev.func == FUNC_OPEN) begin
            scan_ips(ev.client_addr, ip_hit, ip_spare);
            ip_slot  = (ip_hit < 0) ? ip_spare : ip_hit;
            pid_slot = (pid_hit < 0) ? pid_spare : pid_hit;
            if (ip_slot < 0 || pid_slot < 0) begin
                // no room: nothing changes
                res.table_full = 1'b1;
            end else begin
                // a relinked pid leaves its old address count alone
                owner_pid[pid_slot]  = ev.proc_id;
                owner_ip[pid_slot]   = ev.client_addr;
                owner_used[pid_slot] = 1'b1;
                if (ip_hit < 0) begin
                    ip_key[ip_slot]   = ev.client_addr;
                    ip_conns[ip_slot] = CNT_W'(1);
                    ip_used[ip_slot]  = 1'b1;
                end else if (ip_conns[ip_slot] != CNT_MAX) begin
                    ip_conns[ip_slot] = ip_conns[ip_slot] + 1'b1;
                end
                res.new_count = ip_conns[ip_slot];
            end
        end else if (pid_hit < 0) begin
            res.pid_unknown = 1'b1;
        end else begin
            // close: decrement linked address, free it at zero, drop the link
            scan_ips(owner_ip[pid_hit], ip_hit, ip_spare);
            if (ip_hit >= 0 && ip_conns[ip_hit] != 0) begin
                ip_conns[ip_hit] = ip_conns[ip_hit] - 1'b1;
                res.new_count    = ip_conns[ip_hit];
                if (ip_conns[ip_hit] == 0)
                    ip_used[ip_hit] = 1'b0;
            end
            owner_used[pid_hit] = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            for (int n = 0; n < ADDR_ENTRIES; n++)
                ip_used[n] = 1'b0;
            for (int n = 0; n < LINK_ENTRIES; n++)
                owner_used[n] = 1'b0;
            pending_outcomes.delete();
            faults = 0;
        end else begin
            // result transfer: check against the oldest outstanding prediction
            if (i_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("unexpected result: count %0d unknown %0b full %0b",
                                 i_out_item.new_count, i_out_item.pid_unknown,
                                 i_out_item.table_full);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (want.new_count !== i_out_item.new_count ||
                        want.pid_unknown !== i_out_item.pid_unknown ||
                        want.table_full !== i_out_item.table_full) begin
                        faults++;
                        if (faults <= MAX_REPORTS) begin
                            $write("result mismatch: expected count %0d unknown %0b full %0b, ",
                                   want.new_count, want.pid_unknown, want.table_full);
                            $display("got count %0d unknown %0b full %0b",
                                     i_out_item.new_count, i_out_item.pid_unknown,
                                     i_out_item.table_full);
                        end
                    end
                end
            end
            // event transfer: predict its outcome
            if (i_in_valid && !i_in_stall)
                pending_outcomes.push_back(apply_conn_event(i_in_item));
        end
        o_pending    <= pending_outcomes.size();
        o_fail_count <= faults;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Top of the per-source connection counter testbench. Drives open/close
// events (a directed set, then pooled churn, an address table fill, and a
// pile-up on one address that fills the link table and saturates the count)
// under changing source/sink pacing, and reports the verdict from the checker.
// ============================================================================
module tb;
    import pscc_pkg::*;

    localparam int HOLD_CYCLES   = 3000;   // long sink hold-off
    localparam int QUIET_LIMIT   = 12000;  // cycles without any transfer
    localparam int SETTLE_CYCLES = 400;    // above one event latency
    localparam int PHASE_ITEMS   = 110;
    localparam int POOL_PIDS     = 24;
    localparam int POOL_ADDRS    = 12;
    localparam int FILL_OPENS    = 70;
    localparam int PILE_PIDS     = 290;
    localparam int PILE_REPEATS  = 330;

    typedef enum int {
        PACE_FREE,
        PACE_SLOW_SOURCE,
        PACE_SLOW_SINK,
        PACE_BOTH
    } t_pace;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    int fail_count;
    int pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_reqs    = 0;
    int sent         = 0;
    int quiet_cycles = 0;

    logic [PID_W-1:0] pid_pool  [POOL_PIDS];
    logic [IP_W-1:0]  addr_pool [POOL_ADDRS];

    per_source_connection_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    pscc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: give up after a long stretch with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sink: random stall, or a counted hold-off when one is requested
    initial begin : sink
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // One event transfer; called and returns at a falling edge
    task automatic send_event(input logic func, input logic [PID_W-1:0] pid,
                              input logic [IP_W-1:0] addr);
        t_in_item ev;
        ev.func        = func;
        ev.proc_id     = pid;
        ev.client_addr = addr;
        case (t_pace'((sent / PHASE_ITEMS) % 4))
            PACE_FREE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            PACE_SLOW_SOURCE: begin
                idle_pct  = 63;
                stall_pct = 0;
            end
            PACE_SLOW_SINK: begin
                idle_pct  = 0;
                stall_pct = 63;
            end
            default: begin
                idle_pct  = 18;
                stall_pct = 18;
            end
        endcase
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent++;
    endtask

    // Stop offering events until every predicted result has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Random mix over small pid/address pools plus full-range noise
    task automatic churn(input int n);
        int r;
        int pick;
        repeat (n) begin
            r    = $urandom_range(99);
            pick = $urandom_range(POOL_PIDS - 1);
            if (r < 10)
                send_event(1'($urandom), PID_W'($urandom), $urandom);
            else if (r < 65)
                send_event(FUNC_OPEN, pid_pool[pick],
                           addr_pool[$urandom_range(POOL_ADDRS - 1)]);
            else
                send_event(FUNC_CLOSE, pid_pool[pick], $urandom);
        end
    endtask

    initial begin : stimulus
        int               k;
        logic [PID_W-1:0] base;
        logic [IP_W-1:0]  hot;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, relink, unknown pid, free and re-create
        send_event(FUNC_CLOSE, '0, '0);
        send_event(FUNC_OPEN, '0, '0);
        send_event(FUNC_OPEN, '1, '1);
        send_event(FUNC_OPEN, PID_W'(1), '0);
        send_event(FUNC_OPEN, '0, '1);
        send_event(FUNC_CLOSE, '0, '0);
        send_event(FUNC_CLOSE, '0, '0);
        send_event(FUNC_CLOSE, PID_W'(1), '1);
        send_event(FUNC_CLOSE, '1, '0);
        send_event(FUNC_OPEN, PID_W'(2), '1);
        send_event(FUNC_CLOSE, PID_W'(2), '0);
        send_event(FUNC_OPEN, PID_W'('h2AAAAA), IP_W'('hAAAA_AAAA));
        send_event(FUNC_OPEN, PID_W'('h155555), IP_W'('h5555_5555));
        send_event(FUNC_OPEN, PID_W'('h155555), IP_W'('hAAAA_AAAA));
        send_event(FUNC_CLOSE, PID_W'('h2AAAAA), '0);
        send_event(FUNC_CLOSE, PID_W'('h155555), '1);
        drain();

        for (k = 0; k < POOL_PIDS; k++)
            pid_pool[k] = PID_W'($urandom);
        for (k = 0; k < POOL_ADDRS; k++)
            addr_pool[k] = $urandom;

        // Sink holds off while the source keeps offering events
        hold_reqs++;
        churn(300);

        // Fill the address table with distinct addresses, then release them
        base = PID_W'($urandom);
        for (k = 0; k < FILL_OPENS; k++)
            send_event(FUNC_OPEN, PID_W'(base + k), $urandom);
        for (k = 0; k < FILL_OPENS; k++)
            send_event(FUNC_CLOSE, PID_W'(base + k), $urandom);
        drain();

        // Pile-up on one address: fills the link table, then saturates the count
        hot  = $urandom;
        base = PID_W'($urandom);
        for (k = 0; k < PILE_PIDS; k++)
            send_event(FUNC_OPEN, PID_W'(base + k), hot);
        for (k = 0; k < PILE_REPEATS; k++)
            send_event(FUNC_OPEN, PID_W'(base + $urandom_range(149)), hot);
        for (k = 0; k < PILE_PIDS; k++)
            send_event(FUNC_CLOSE, PID_W'(base + k), $urandom);

        churn(300);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ per_source_connection_counter.f @@
sv/pscc_pkg.sv
sv/pscc_ram.sv
sv/pscc_ctrl.sv
sv/pscc_dp.sv
sv/per_source_connection_counter.sv
sim/pscc_checker.sv
sim/tb.sv
